>>> hw/rtl/sicxe_pkg.sv
// Package with shared types, constants and opcodes for the SIC/XE execute core.
`timescale 1ns / 1ps
`default_nettype none
package sicxe_pkg;

  localparam int unsigned MEM_BYTES_DEF = 32768;

  typedef struct packed {
    logic        op;
    logic [19:0] load_addr;
    logic [7:0]  load_byte;
    logic [7:0]  opcode;
    logic [2:0]  format;
    logic [19:0] operand;
    logic [5:0]  mode_bits;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] acc;
    logic [23:0] index_out;
    logic [23:0] link_out;
    logic [23:0] base_out;
    logic [23:0] s_out;
    logic [23:0] t_out;
    logic [23:0] pc_out;
    logic [23:0] sw_out;
    logic [1:0]  cond_out;
  } out_word_t;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ADDR  = 2'd1;
  localparam logic [1:0] ST_BADREG = 2'd2;
  localparam logic [1:0] ST_DIV0  = 2'd3;

  // Condition codes.
  localparam logic [1:0] CC_LT = 2'd0;
  localparam logic [1:0] CC_EQ = 2'd1;
  localparam logic [1:0] CC_GT = 2'd2;

  // Format-2 opcodes.
  localparam logic [7:0] OP_ADDR   = 8'h90;
  localparam logic [7:0] OP_CLEAR  = 8'hB4;
  localparam logic [7:0] OP_COMPR  = 8'hA0;
  localparam logic [7:0] OP_DIVR   = 8'h9C;
  localparam logic [7:0] OP_MULR   = 8'h98;
  localparam logic [7:0] OP_RMO    = 8'hAC;
  localparam logic [7:0] OP_SHIFTL = 8'hA4;
  localparam logic [7:0] OP_SHIFTR = 8'hA8;
  localparam logic [7:0] OP_SUBR   = 8'h94;
  localparam logic [7:0] OP_TIXR   = 8'hB8;

  // Format-3/4 opcodes.
  localparam logic [7:0] OP_ADD  = 8'h18;
  localparam logic [7:0] OP_AND  = 8'h40;
  localparam logic [7:0] OP_COMP = 8'h28;
  localparam logic [7:0] OP_DIV  = 8'h24;
  localparam logic [7:0] OP_J    = 8'h3C;
  localparam logic [7:0] OP_JEQ  = 8'h30;
  localparam logic [7:0] OP_JGT  = 8'h34;
  localparam logic [7:0] OP_JLT  = 8'h38;
  localparam logic [7:0] OP_JSUB = 8'h48;
  localparam logic [7:0] OP_LDA  = 8'h00;
  localparam logic [7:0] OP_LDB  = 8'h68;
  localparam logic [7:0] OP_LDCH = 8'h50;
  localparam logic [7:0] OP_LDL  = 8'h08;
  localparam logic [7:0] OP_LDS  = 8'h6C;
  localparam logic [7:0] OP_LDT  = 8'h74;
  localparam logic [7:0] OP_LDX  = 8'h04;
  localparam logic [7:0] OP_MUL  = 8'h20;
  localparam logic [7:0] OP_OR   = 8'h44;
  localparam logic [7:0] OP_RSUB = 8'h4C;
  localparam logic [7:0] OP_STA  = 8'h0C;
  localparam logic [7:0] OP_STB  = 8'h78;
  localparam logic [7:0] OP_STCH = 8'h54;
  localparam logic [7:0] OP_STL  = 8'h14;
  localparam logic [7:0] OP_STS  = 8'h7C;
  localparam logic [7:0] OP_STSW = 8'hE8;
  localparam logic [7:0] OP_STT  = 8'h84;
  localparam logic [7:0] OP_STX  = 8'h10;
  localparam logic [7:0] OP_SUB  = 8'h1C;
  localparam logic [7:0] OP_TD   = 8'hE0;
  localparam logic [7:0] OP_TIX  = 8'h2C;

  // Register numbers.
  localparam logic [3:0] RN_A  = 4'd0;
  localparam logic [3:0] RN_X  = 4'd1;
  localparam logic [3:0] RN_L  = 4'd2;
  localparam logic [3:0] RN_B  = 4'd3;
  localparam logic [3:0] RN_S  = 4'd4;
  localparam logic [3:0] RN_T  = 4'd5;
  localparam logic [3:0] RN_PC = 4'd8;
  localparam logic [3:0] RN_SW = 4'd9;

  // Signed 24-bit three-way compare.
  function automatic logic [1:0] cmp3(input logic [23:0] a, input logic [23:0] b);
    logic signed [23:0] sa;
    logic signed [23:0] sb;
    sa = a;
    sb = b;
    if (sa < sb) begin
      cmp3 = CC_LT;
    end else if (sa == sb) begin
      cmp3 = CC_EQ;
    end else begin
      cmp3 = CC_GT;
    end
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/sicxe_instruction_execute_core.sv
// SIC/XE execute core: sequencer, register file and byte memory control.
//
// Usage: one input word per item on in_valid/in_ready; each item yields one
// output word on out_valid/out_ready with the full register set after the step.
// A write word (op 0) stores one byte in the byte memory. An execute word
// (op 1) runs one decoded instruction. Memory operands are read one byte per
// cycle from a single-port RAM with registered read; an indirect word operand
// first reads its pointer word, a word store writes three bytes, and DIV and
// DIVR wait on the iterative divider. One item is in work at a time.
// The result sits in an output register; the next item is taken while it
// waits, and its result is held back until the receiver takes the first.
// Reset clears all registers to zero and the condition code to equal; the
// memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module sicxe_instruction_execute_core
  import sicxe_pkg::*;
#(
  parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  localparam int unsigned AW = $clog2(MEM_BYTES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_IND   = 4'd2;
  localparam logic [3:0] S_OPRD  = 4'd3;
  localparam logic [3:0] S_APPLY = 4'd4;
  localparam logic [3:0] S_STORE = 4'd5;
  localparam logic [3:0] S_DIVW  = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  logic [3:0]  state;
  in_word_t    item;
  logic [23:0] reg_a, reg_x, reg_l, reg_b, reg_s, reg_t, reg_pc, reg_sw;
  logic [1:0]  cond;
  logic [1:0]  status;
  logic [23:0] ta;
  logic [23:0] ea;
  logic [23:0] val;
  logic [23:0] sdata;
  logic [1:0]  bcnt;
  logic        rd_pend;

  // Memory port.
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;

  sicxe_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
  );

  // Divider.
  logic        div_start;
  logic [23:0] div_num, div_den;
  logic        div_done;
  logic [23:0] div_quot;

  sicxe_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_quot)
  );

  // Decode helpers.
  logic [7:0] opc;
  logic [1:0] ni;
  logic [3:0] n1, n2;
  logic       kind_load, kind_ea;
  assign opc = {item.opcode[7:2], 2'b00};
  assign ni  = item.mode_bits[5:4];
  assign n1  = item.operand[7:4];
  assign n2  = item.operand[3:0];

  always_comb begin
    kind_load = 1'b0;
    kind_ea   = 1'b0;
    unique case (opc)
      OP_ADD, OP_AND, OP_COMP, OP_DIV, OP_LDA, OP_LDB, OP_LDCH, OP_LDL, OP_LDS,
      OP_LDT, OP_LDX, OP_MUL, OP_OR, OP_SUB, OP_TIX: kind_load = 1'b1;
      OP_J, OP_JEQ, OP_JGT, OP_JLT, OP_JSUB, OP_STA, OP_STB, OP_STCH, OP_STL,
      OP_STS, OP_STSW, OP_STT, OP_STX: kind_ea = 1'b1;
      default: ;
    endcase
  end

  function automatic logic reg_ok(input logic [3:0] n);
    reg_ok = (n <= RN_T) || (n == RN_PC) || (n == RN_SW);
  endfunction

  function automatic logic [23:0] reg_rd(input logic [3:0] n, input logic [23:0] a,
      input logic [23:0] x, input logic [23:0] l, input logic [23:0] b,
      input logic [23:0] s, input logic [23:0] t, input logic [23:0] pc,
      input logic [23:0] sw);
    unique case (n)
      RN_A:  reg_rd = a;
      RN_X:  reg_rd = x;
      RN_L:  reg_rd = l;
      RN_B:  reg_rd = b;
      RN_S:  reg_rd = s;
      RN_T:  reg_rd = t;
      RN_PC: reg_rd = pc;
      RN_SW: reg_rd = sw;
      default: reg_rd = '0;
    endcase
  endfunction

  logic [23:0] r1v, r2v;
  assign r1v = reg_rd(n1, reg_a, reg_x, reg_l, reg_b, reg_s, reg_t, reg_pc, reg_sw);
  assign r2v = reg_rd(n2, reg_a, reg_x, reg_l, reg_b, reg_s, reg_t, reg_pc, reg_sw);

  // Program counter advanced by the instruction length.
  logic [23:0] pc_adv;
  assign pc_adv = reg_pc + {21'd0, item.format};

  // Target address from the displacement or the format-4 address.
  logic [23:0] ta_calc;
  always_comb begin
    logic [23:0] base;
    base = '0;
    if (item.format == 3'd4) begin
      base = {4'd0, item.operand};
    end else if (item.mode_bits[1]) begin
      base = pc_adv + {{12{item.operand[11]}}, item.operand[11:0]};
    end else if (item.mode_bits[2]) begin
      base = reg_b + {12'd0, item.operand[11:0]};
    end else begin
      base = {12'd0, item.operand[11:0]};
    end
    ta_calc = item.mode_bits[3] ? base + reg_x : base;
  end

  // Word and byte range checks.
  function automatic logic word_ok(input logic [23:0] a);
    word_ok = ({1'b0, a} + 25'd2) < 25'(MEM_BYTES);
  endfunction
  function automatic logic byte_ok(input logic [23:0] a);
    byte_ok = {1'b0, a} < 25'(MEM_BYTES);
  endfunction

  // Circular and arithmetic shifts.
  logic [4:0]  sh;
  logic [23:0] shl_v, shr_v;
  logic [47:0] dbl;
  assign sh    = {1'b0, n2} + 5'd1;
  assign dbl   = {r1v, r1v} << sh;
  assign shl_v = dbl[47:24];
  assign shr_v = 24'($signed(r1v) >>> sh);

  // Single multiplier, 24 by 24, low half kept.
  logic [23:0] mul_a, mul_b;
  logic [47:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // Value written back by a register-to-register operation.
  logic [23:0] wreg;
  always_comb begin
    unique case (opc)
      OP_CLEAR:  wreg = 24'd0;
      OP_SHIFTL: wreg = shl_v;
      OP_SHIFTR: wreg = shr_v;
      OP_ADDR:   wreg = r2v + r1v;
      OP_SUBR:   wreg = r2v - r1v;
      OP_MULR:   wreg = mul_p[23:0];
      default:   wreg = r1v;
    endcase
  end

  // State that follows the apply step: divide wait, store, or done.
  logic [3:0] apply_state;
  always_comb begin
    apply_state = S_DONE;
    if (item.format == 3'd2) begin
      if (opc == OP_DIVR && r1v != 24'd0) begin
        apply_state = S_DIVW;
      end
    end else if (opc == OP_DIV) begin
      if (val != 24'd0) begin
        apply_state = S_DIVW;
      end
    end else if (opc == OP_STCH) begin
      if (byte_ok(ea)) begin
        apply_state = S_STORE;
      end
    end else if (opc == OP_STA || opc == OP_STB || opc == OP_STL || opc == OP_STS ||
                 opc == OP_STSW || opc == OP_STT || opc == OP_STX) begin
      if (word_ok(ea)) begin
        apply_state = S_STORE;
      end
    end
  end

  assign in_ready = (state == S_IDLE);

  // The result register takes a new word when it is empty or being emptied.
  logic res_take;
  assign res_take = (state == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      reg_a <= '0; reg_x <= '0; reg_l <= '0; reg_b <= '0;
      reg_s <= '0; reg_t <= '0; reg_pc <= '0; reg_sw <= '0;
      cond <= CC_EQ;
      out_valid <= 1'b0;
      rd_pend <= 1'b0;
      bcnt <= '0;
    end else begin
      if (res_take) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item   <= in_data;
            status <= ST_OK;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (!item.op) begin
            if (!byte_ok({4'd0, item.load_addr})) begin
              status <= ST_ADDR;
            end
            state <= S_DONE;
          end else if (item.format >= 3'd1 && item.format <= 3'd4) begin
            reg_pc <= pc_adv;
            if (item.format == 3'd2) begin
              if (((opc == OP_ADDR || opc == OP_COMPR || opc == OP_DIVR ||
                    opc == OP_MULR || opc == OP_RMO || opc == OP_SUBR) &&
                   (!reg_ok(n1) || !reg_ok(n2))) ||
                  ((opc == OP_CLEAR || opc == OP_SHIFTL || opc == OP_SHIFTR ||
                    opc == OP_TIXR) && !reg_ok(n1))) begin
                status <= ST_BADREG;
                state <= S_DONE;
              end else begin
                state <= S_APPLY;
              end
            end else if (item.format >= 3'd3 && ni != 2'b00) begin
              ta <= ta_calc;
              ea <= ta_calc;
              bcnt <= '0;
              rd_pend <= 1'b0;
              if ((kind_load || kind_ea) && ni == 2'b10) begin
                state <= S_IND;
              end else if (kind_load && ni != 2'b01) begin
                state <= S_OPRD;
              end else begin
                val <= ta_calc;
                state <= S_APPLY;
              end
            end else begin
              state <= S_DONE;
            end
          end else begin
            state <= S_DONE;
          end
        end
        S_IND: begin
          // Fetch the pointer word from ta, one byte a cycle.
          if (!word_ok(ta)) begin
            status <= ST_ADDR;
            state <= S_DONE;
          end else begin
            if (rd_pend) begin
              ea <= {ea[15:0], mem_rdata};
            end
            if (bcnt == 2'd3) begin
              bcnt <= '0;
              rd_pend <= 1'b0;
              state <= kind_load ? S_OPRD : S_APPLY;
            end else begin
              rd_pend <= 1'b1;
              bcnt <= bcnt + 2'd1;
            end
          end
        end
        S_OPRD: begin
          // Operand byte or word at ea.
          if (opc == OP_LDCH) begin
            if (!byte_ok(ea)) begin
              status <= ST_ADDR;
              state <= S_DONE;
            end else if (rd_pend) begin
              val <= {16'd0, mem_rdata};
              rd_pend <= 1'b0;
              state <= S_APPLY;
            end else begin
              rd_pend <= 1'b1;
            end
          end else if (!word_ok(ea)) begin
            status <= ST_ADDR;
            state <= S_DONE;
          end else begin
            if (rd_pend) begin
              val <= {val[15:0], mem_rdata};
            end
            if (bcnt == 2'd3) begin
              bcnt <= '0;
              rd_pend <= 1'b0;
              state <= S_APPLY;
            end else begin
              rd_pend <= 1'b1;
              bcnt <= bcnt + 2'd1;
            end
          end
        end
        S_APPLY: begin
          state <= apply_state;
          if (item.format == 3'd2) begin
            if (opc == OP_DIVR) begin
              if (r1v == 24'd0) begin
                status <= ST_DIV0;
              end
            end else if (opc == OP_COMPR) begin
              cond <= cmp3(r1v, r2v);
            end else if (opc == OP_TIXR) begin
              reg_x <= reg_x + 24'd1;
              cond <= cmp3(reg_x + 24'd1, (n1 == RN_X) ? reg_x + 24'd1 : r1v);
            end else if (opc == OP_ADDR || opc == OP_SUBR || opc == OP_MULR ||
                         opc == OP_RMO) begin
              unique case (n2)
                RN_A: reg_a <= wreg;  RN_X: reg_x <= wreg;
                RN_L: reg_l <= wreg;  RN_B: reg_b <= wreg;
                RN_S: reg_s <= wreg;  RN_T: reg_t <= wreg;
                RN_PC: reg_pc <= wreg; RN_SW: reg_sw <= wreg;
                default: ;
              endcase
            end else if (opc == OP_CLEAR || opc == OP_SHIFTL || opc == OP_SHIFTR) begin
              unique case (n1)
                RN_A: reg_a <= wreg;  RN_X: reg_x <= wreg;
                RN_L: reg_l <= wreg;  RN_B: reg_b <= wreg;
                RN_S: reg_s <= wreg;  RN_T: reg_t <= wreg;
                RN_PC: reg_pc <= wreg; RN_SW: reg_sw <= wreg;
                default: ;
              endcase
            end
          end else begin
            unique case (opc)
              OP_ADD:  reg_a <= reg_a + val;
              OP_AND:  reg_a <= reg_a & val;
              OP_OR:   reg_a <= reg_a | val;
              OP_SUB:  reg_a <= reg_a - val;
              OP_MUL:  reg_a <= mul_p[23:0];
              OP_COMP: cond <= cmp3(reg_a, val);
              OP_DIV: begin
                if (val == 24'd0) begin
                  status <= ST_DIV0;
                end
              end
              OP_J:    reg_pc <= ea;
              OP_JEQ:  if (cond == CC_EQ) reg_pc <= ea;
              OP_JGT:  if (cond == CC_GT) reg_pc <= ea;
              OP_JLT:  if (cond == CC_LT) reg_pc <= ea;
              OP_JSUB: begin
                reg_l <= reg_pc;
                reg_pc <= ea;
              end
              OP_LDA:  reg_a <= val;
              OP_LDB:  reg_b <= val;
              OP_LDCH: reg_a <= {reg_a[23:8], val[7:0]};
              OP_LDL:  reg_l <= val;
              OP_LDS:  reg_s <= val;
              OP_LDT:  reg_t <= val;
              OP_LDX:  reg_x <= val;
              OP_RSUB: reg_pc <= reg_l;
              OP_TD:   cond <= CC_LT;
              OP_TIX: begin
                reg_x <= reg_x + 24'd1;
                cond <= cmp3(reg_x + 24'd1, val);
              end
              OP_STCH: begin
                if (!byte_ok(ea)) begin
                  status <= ST_ADDR;
                end else begin
                  sdata <= {reg_a[7:0], 16'd0};
                  bcnt <= 2'd2;
                end
              end
              OP_STA, OP_STB, OP_STL, OP_STS, OP_STSW, OP_STT, OP_STX: begin
                if (!word_ok(ea)) begin
                  status <= ST_ADDR;
                end else begin
                  unique case (opc)
                    OP_STA:  sdata <= reg_a;
                    OP_STB:  sdata <= reg_b;
                    OP_STL:  sdata <= reg_l;
                    OP_STS:  sdata <= reg_s;
                    OP_STSW: sdata <= reg_sw;
                    OP_STT:  sdata <= reg_t;
                    default: sdata <= reg_x;
                  endcase
                  bcnt <= 2'd0;
                end
              end
              default: ;
            endcase
          end
        end
        S_STORE: begin
          // Write the word high byte first.
          sdata <= {sdata[15:0], 8'd0};
          ea <= ea + 24'd1;
          if (bcnt == 2'd2) begin
            bcnt <= '0;
            state <= S_DONE;
          end else begin
            bcnt <= bcnt + 2'd1;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            state <= S_DONE;
            if (item.format == 3'd2) begin
              unique case (n2)
                RN_A: reg_a <= div_quot;  RN_X: reg_x <= div_quot;
                RN_L: reg_l <= div_quot;  RN_B: reg_b <= div_quot;
                RN_S: reg_s <= div_quot;  RN_T: reg_t <= div_quot;
                RN_PC: reg_pc <= div_quot; RN_SW: reg_sw <= div_quot;
                default: ;
              endcase
            end else begin
              reg_a <= div_quot;
            end
          end
        end
        S_DONE: begin
          // Hand the result over once the output register is free.
          if (res_take) begin
            out_data.status    <= status;
            out_data.acc       <= reg_a;
            out_data.index_out <= reg_x;
            out_data.link_out  <= reg_l;
            out_data.base_out  <= reg_b;
            out_data.s_out     <= reg_s;
            out_data.t_out     <= reg_t;
            out_data.pc_out    <= reg_pc;
            out_data.sw_out    <= reg_sw;
            out_data.cond_out  <= cond;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Divider start pulse on entry to the wait state.
  assign div_start = (state == S_APPLY) && (apply_state == S_DIVW);
  assign div_num = (item.format == 3'd2) ? r2v : reg_a;
  assign div_den = (item.format == 3'd2) ? r1v : val;

  assign mul_a = (item.format == 3'd2) ? r2v : reg_a;
  assign mul_b = (item.format == 3'd2) ? r1v : val;

  // Memory port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = sdata[23:16];
    unique case (state)
      S_EXEC: begin
        mem_we    = !item.op && byte_ok({4'd0, item.load_addr});
        mem_addr  = AW'(item.load_addr);
        mem_wdata = item.load_byte;
      end
      S_IND:   mem_addr = AW'(ta + {22'd0, bcnt});
      S_OPRD:  mem_addr = AW'(ea + {22'd0, (opc == OP_LDCH) ? 2'd0 : bcnt});
      S_STORE: begin
        mem_we   = 1'b1;
        mem_addr = AW'(ea);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/sicxe_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module sicxe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_array [DEPTH];

  // One access per cycle; the read returns on the next edge.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_array[addr] <= wdata;
    end
    rdata <= mem_array[addr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/sicxe_divider.sv
// Iterative signed 24-bit divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
`default_nettype none
module sicxe_divider
  import sicxe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [23:0] num,
  input  wire logic [23:0] den,
  output logic             done,
  output logic [23:0]      quot
);

  logic        busy;
  logic [4:0]  count;
  logic [23:0] rem;
  logic [23:0] q;
  logic [23:0] dmag;
  logic        neg;
  logic [24:0] trial;

  assign trial = {rem, q[23]} - {1'b0, dmag};
  assign quot  = neg ? 24'(-q) : q;

  // Restoring division on magnitudes, sign fixed at the end.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 5'd0;
        rem   <= '0;
        q     <= num[23] ? 24'(-num) : num;
        dmag  <= den[23] ? 24'(-den) : den;
        neg   <= num[23] ^ den[23];
      end else if (busy) begin
        if (!trial[24]) begin
          rem <= trial[23:0];
          q   <= {q[22:0], 1'b1};
        end else begin
          rem <= {rem[22:0], q[23]};
          q   <= {q[22:0], 1'b0};
        end
        count <= count + 5'd1;
        if (count == 5'd23) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> tb/sicxe_instruction_execute_core_test.sv
// Self-checking testbench for the SIC/XE execute core with a built-in instruction predictor.
`timescale 1ns / 1ps
`default_nettype none
module sicxe_instruction_execute_core_test;
  import sicxe_pkg::*;

  localparam int MEM_SIZE = MEM_BYTES_DEF;
  localparam int RANDOM_WORDS = 700;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;

  sicxe_instruction_execute_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Predicted architectural state.
  logic [23:0] regfile[16];
  logic [1:0] cc_now;
  logic [7:0] mem_img[MEM_SIZE];
  bit mem_known[MEM_SIZE];

  out_word_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;

  function automatic bit reg_exists(logic [3:0] n);
    return (n <= RN_T) || (n == RN_PC) || (n == RN_SW);
  endfunction

  function automatic logic [1:0] signed_order(logic [23:0] a, logic [23:0] b);
    int sa;
    int sb;
    sa = $signed(a);
    sb = $signed(b);
    if (sa < sb) begin
      return CC_LT;
    end
    return (sa == sb) ? CC_EQ : CC_GT;
  endfunction

  function automatic logic [23:0] quotient24(logic [23:0] num, logic [23:0] den);
    int sn;
    int sd;
    int q;
    sn = $signed(num);
    sd = $signed(den);
    q = sn / sd;
    return q[23:0];
  endfunction

  // Reads one byte of the image and remembers the first byte never written.
  function automatic logic [7:0] peek(int a, inout int blank);
    if (!mem_known[a] && blank < 0) begin
      blank = a;
    end
    return mem_img[a];
  endfunction

  function automatic bit fetch_word(int a, inout int blank, output logic [23:0] v);
    v = '0;
    if (a + 2 >= MEM_SIZE) begin
      return 1'b0;
    end
    v = {peek(a, blank), peek(a + 1, blank), peek(a + 2, blank)};
    return 1'b1;
  endfunction

  // Computes the result of one word; state is updated only when commit is set.
  function automatic void execute_word(input in_word_t w, input bit commit,
                                       output out_word_t o, output int blank);
    logic [23:0] r[16];
    logic [1:0] cc;
    logic [1:0] st;
    logic [7:0] opc;
    logic [3:0] n1;
    logic [3:0] n2;
    logic [4:0] sh;
    logic [47:0] dbl;
    logic [1:0] ni;
    logic [23:0] ta;
    logic [23:0] ea;
    logic [23:0] val;
    logic [23:0] sv;
    logic [11:0] d;
    bit both;
    bit one;
    int kind;
    int sa;
    int slen;
    r = regfile;
    cc = cc_now;
    st = ST_OK;
    blank = -1;
    slen = 0;
    sa = 0;
    sv = '0;
    val = '0;
    opc = {w.opcode[7:2], 2'b00};
    if (!w.op) begin
      if (w.load_addr < MEM_SIZE) begin
        slen = 1;
        sa = w.load_addr;
        sv = {16'd0, w.load_byte};
      end else begin
        st = ST_ADDR;
      end
    end else if (w.format >= 3'd1 && w.format <= 3'd4) begin
      r[RN_PC] = r[RN_PC] + w.format;
      if (w.format == 3'd2) begin
        // Register-to-register operations.
        n1 = w.operand[7:4];
        n2 = w.operand[3:0];
        sh = n2 + 5'd1;
        both = opc inside {OP_ADDR, OP_COMPR, OP_DIVR, OP_MULR, OP_RMO, OP_SUBR};
        one = opc inside {OP_CLEAR, OP_SHIFTL, OP_SHIFTR, OP_TIXR};
        if ((both && !(reg_exists(n1) && reg_exists(n2))) || (one && !reg_exists(n1))) begin
          st = ST_BADREG;
        end else begin
          case (opc)
            OP_ADDR: r[n2] = r[n2] + r[n1];
            OP_CLEAR: r[n1] = '0;
            OP_COMPR: cc = signed_order(r[n1], r[n2]);
            OP_DIVR: begin
              if (r[n1] == '0) begin
                st = ST_DIV0;
              end else begin
                r[n2] = quotient24(r[n2], r[n1]);
              end
            end
            OP_MULR: r[n2] = r[n2] * r[n1];
            OP_RMO: r[n2] = r[n1];
            OP_SHIFTL: begin
              dbl = {r[n1], r[n1]} << sh;
              r[n1] = dbl[47:24];
            end
            OP_SHIFTR: r[n1] = $signed(r[n1]) >>> sh;
            OP_SUBR: r[n2] = r[n2] - r[n1];
            OP_TIXR: begin
              r[RN_X] = r[RN_X] + 24'd1;
              cc = signed_order(r[RN_X], r[n1]);
            end
            default: ;
          endcase
        end
      end else if (w.format >= 3'd3 && w.mode_bits[5:4] != 2'b00) begin
        // Target address from the addressing flags.
        ni = w.mode_bits[5:4];
        d = w.operand[11:0];
        if (w.format == 3'd4) begin
          ta = {4'd0, w.operand};
        end else if (w.mode_bits[1]) begin
          ta = r[RN_PC] + {{12{d[11]}}, d};
        end else if (w.mode_bits[2]) begin
          ta = r[RN_B] + {12'd0, d};
        end else begin
          ta = {12'd0, d};
        end
        if (w.mode_bits[3]) begin
          ta = ta + r[RN_X];
        end
        case (opc)
          OP_ADD, OP_AND, OP_COMP, OP_DIV, OP_LDA, OP_LDB, OP_LDCH, OP_LDL, OP_LDS,
          OP_LDT, OP_LDX, OP_MUL, OP_OR, OP_SUB, OP_TIX: kind = 1;
          OP_J, OP_JEQ, OP_JGT, OP_JLT, OP_JSUB, OP_STA, OP_STB, OP_STCH, OP_STL,
          OP_STS, OP_STSW, OP_STT, OP_STX: kind = 2;
          default: kind = 0;
        endcase
        ea = ta;
        if (kind != 0 && ni == 2'b10 && !fetch_word(ta, blank, ea)) begin
          st = ST_ADDR;
        end
        if (st == ST_OK && kind == 1) begin
          if (ni == 2'b01) begin
            val = ta;
          end else if (opc == OP_LDCH) begin
            if (ea >= MEM_SIZE) begin
              st = ST_ADDR;
            end else begin
              val = {16'd0, peek(ea, blank)};
            end
          end else if (!fetch_word(ea, blank, val)) begin
            st = ST_ADDR;
          end
        end
        if (st == ST_OK) begin
          case (opc)
            OP_ADD: r[RN_A] = r[RN_A] + val;
            OP_AND: r[RN_A] = r[RN_A] & val;
            OP_COMP: cc = signed_order(r[RN_A], val);
            OP_DIV: begin
              if (val == '0) begin
                st = ST_DIV0;
              end else begin
                r[RN_A] = quotient24(r[RN_A], val);
              end
            end
            OP_J: r[RN_PC] = ea;
            OP_JEQ: if (cc == CC_EQ) r[RN_PC] = ea;
            OP_JGT: if (cc == CC_GT) r[RN_PC] = ea;
            OP_JLT: if (cc == CC_LT) r[RN_PC] = ea;
            OP_JSUB: begin
              r[RN_L] = r[RN_PC];
              r[RN_PC] = ea;
            end
            OP_LDA: r[RN_A] = val;
            OP_LDB: r[RN_B] = val;
            OP_LDCH: r[RN_A][7:0] = val[7:0];
            OP_LDL: r[RN_L] = val;
            OP_LDS: r[RN_S] = val;
            OP_LDT: r[RN_T] = val;
            OP_LDX: r[RN_X] = val;
            OP_MUL: r[RN_A] = r[RN_A] * val;
            OP_OR: r[RN_A] = r[RN_A] | val;
            OP_RSUB: r[RN_PC] = r[RN_L];
            OP_SUB: r[RN_A] = r[RN_A] - val;
            OP_TD: cc = CC_LT;
            OP_TIX: begin
              r[RN_X] = r[RN_X] + 24'd1;
              cc = signed_order(r[RN_X], val);
            end
            OP_STCH: begin
              if (ea >= MEM_SIZE) begin
                st = ST_ADDR;
              end else begin
                slen = 1;
                sa = ea;
                sv = r[RN_A];
              end
            end
            OP_STA, OP_STB, OP_STL, OP_STS, OP_STSW, OP_STT, OP_STX: begin
              case (opc)
                OP_STA: sv = r[RN_A];
                OP_STB: sv = r[RN_B];
                OP_STL: sv = r[RN_L];
                OP_STS: sv = r[RN_S];
                OP_STSW: sv = r[RN_SW];
                OP_STT: sv = r[RN_T];
                default: sv = r[RN_X];
              endcase
              if (ea + 2 >= MEM_SIZE) begin
                st = ST_ADDR;
              end else begin
                slen = 3;
                sa = ea;
              end
            end
            default: ;
          endcase
        end
      end
    end
    // A fault keeps everything but the advanced program counter.
    if (st != ST_OK) begin
      slen = 0;
      ta = r[RN_PC];
      r = regfile;
      r[RN_PC] = ta;
      cc = cc_now;
    end
    if (commit) begin
      regfile = r;
      cc_now = cc;
      for (int k = 0; k < slen; k++) begin
        mem_img[sa + k] = (slen == 3) ? sv[23 - 8 * k -: 8] : sv[7:0];
        mem_known[sa + k] = 1'b1;
      end
    end
    o.status = st;
    o.acc = r[RN_A];
    o.index_out = r[RN_X];
    o.link_out = r[RN_L];
    o.base_out = r[RN_B];
    o.s_out = r[RN_S];
    o.t_out = r[RN_T];
    o.pc_out = r[RN_PC];
    o.sw_out = r[RN_SW];
    o.cond_out = cc;
  endfunction

  // Hands one word to the core and records its expected result.
  task automatic send_word(input in_word_t w, input bit typed, input logic [1:0] typed_status);
    out_word_t o;
    int blank;
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    execute_word(w, 1'b1, o, blank);
    if (typed) begin
      o.status = typed_status;
    end
    pending_results.push_back(o);
  endtask

  function automatic in_word_t byte_write(int a, logic [7:0] b);
    in_word_t w;
    w = $urandom();
    w.op = 1'b0;
    w.load_addr = a;
    w.load_byte = b;
    return w;
  endfunction

  function automatic in_word_t instr(logic [7:0] opc, logic [2:0] fmt,
                                     logic [19:0] operand, logic [5:0] mode);
    in_word_t w;
    w = $urandom();
    w.op = 1'b1;
    w.opcode = opc | 8'($urandom_range(0, 3));
    w.format = fmt;
    w.operand = operand;
    w.mode_bits = mode;
    return w;
  endfunction

  typedef struct {
    in_word_t w;
    bit typed;
    logic [1:0] status;
  } stim_row_t;

  // Random byte write or instruction, biased toward in-range addresses.
  function automatic in_word_t random_word();
    logic [7:0] fmt2_ops[10] = '{OP_ADDR, OP_CLEAR, OP_COMPR, OP_DIVR, OP_MULR, OP_RMO,
                                 OP_SHIFTL, OP_SHIFTR, OP_SUBR, OP_TIXR};
    logic [7:0] fmt34_ops[30] = '{OP_ADD, OP_AND, OP_COMP, OP_DIV, OP_J, OP_JEQ, OP_JGT,
                                  OP_JLT, OP_JSUB, OP_LDA, OP_LDB, OP_LDCH, OP_LDL, OP_LDS,
                                  OP_LDT, OP_LDX, OP_MUL, OP_OR, OP_RSUB, OP_STA, OP_STB,
                                  OP_STCH, OP_STL, OP_STS, OP_STSW, OP_STT, OP_STX, OP_SUB,
                                  OP_TD, OP_TIX};
    logic [3:0] good_regs[8] = '{RN_A, RN_X, RN_L, RN_B, RN_S, RN_T, RN_PC, RN_SW};
    in_word_t w;
    int pick;
    logic [5:0] mode;
    logic [19:0] operand;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      if ($urandom_range(0, 9) == 0) begin
        return byte_write($urandom_range(0, 20'hFFFFF), $urandom());
      end
      return byte_write($urandom_range(0, 700), $urandom());
    end
    if (pick < 40) begin
      operand = $urandom();
      operand[7:4] = ($urandom_range(0, 9) == 0) ? 4'($urandom()) : good_regs[$urandom_range(0, 7)];
      operand[3:0] = ($urandom_range(0, 9) == 0) ? 4'($urandom()) : good_regs[$urandom_range(0, 7)];
      return instr(fmt2_ops[$urandom_range(0, 9)], 3'd2, operand, $urandom());
    end
    mode = $urandom();
    case ($urandom_range(0, 9))
      0: mode[5:4] = 2'b00;
      1, 2: mode[5:4] = 2'b10;
      3, 4, 5: mode[5:4] = 2'b01;
      default: mode[5:4] = 2'b11;
    endcase
    if ($urandom_range(0, 2) != 0) mode[3] = 1'b0;
    if ($urandom_range(0, 2) != 0) mode[1] = 1'b0;
    operand = ($urandom_range(0, 7) == 0) ? 20'($urandom()) : 20'($urandom_range(0, 600));
    if ($urandom_range(0, 3) == 0 && mode[1]) operand[11:0] = -12'($urandom_range(0, 64));
    w = instr(($urandom_range(0, 9) == 0) ? 8'($urandom()) : fmt34_ops[$urandom_range(0, 29)],
              ($urandom_range(0, 1) == 0) ? 3'd3 : 3'd4, operand, mode);
    if ($urandom_range(0, 19) == 0) begin
      w.format = $urandom();
    end
    return w;
  endfunction

  // Cycle budget.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("sicxe_instruction_execute_core_test failed");
      $finish;
    end
  end

  // Receiver stalls in random bursts.
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result check, sampled on the falling edge before the transfer edge.
  always @(negedge clk) begin
    out_word_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_data.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_data.status); errors++;
        end
        if (out_data.acc !== e.acc) begin
          $error("acc: expected %h, got %h", e.acc, out_data.acc); errors++;
        end
        if (out_data.index_out !== e.index_out) begin
          $error("index_out: expected %h, got %h", e.index_out, out_data.index_out); errors++;
        end
        if (out_data.link_out !== e.link_out) begin
          $error("link_out: expected %h, got %h", e.link_out, out_data.link_out); errors++;
        end
        if (out_data.base_out !== e.base_out) begin
          $error("base_out: expected %h, got %h", e.base_out, out_data.base_out); errors++;
        end
        if (out_data.s_out !== e.s_out) begin
          $error("s_out: expected %h, got %h", e.s_out, out_data.s_out); errors++;
        end
        if (out_data.t_out !== e.t_out) begin
          $error("t_out: expected %h, got %h", e.t_out, out_data.t_out); errors++;
        end
        if (out_data.pc_out !== e.pc_out) begin
          $error("pc_out: expected %h, got %h", e.pc_out, out_data.pc_out); errors++;
        end
        if (out_data.sw_out !== e.sw_out) begin
          $error("sw_out: expected %h, got %h", e.sw_out, out_data.sw_out); errors++;
        end
        if (out_data.cond_out !== e.cond_out) begin
          $error("cond_out: expected %0d, got %0d", e.cond_out, out_data.cond_out); errors++;
        end
      end
    end
  end

  // Stimulus: directed table, then random words.
  initial begin
    stim_row_t rows[$];
    in_word_t w;
    out_word_t probe;
    int blank;
    int waited;
    for (int k = 0; k < 16; k++) regfile[k] = '0;
    cc_now = CC_EQ;
    for (int k = 0; k < MEM_SIZE; k++) mem_known[k] = 1'b0;
    rows = '{
      '{byte_write(0, 8'h00), 1'b1, ST_OK},
      '{byte_write(20'hFFFFF, 8'hFF), 1'b1, ST_ADDR},
      '{byte_write(1, 8'h00), 1'b1, ST_OK},
      '{byte_write(2, 8'h05), 1'b1, ST_OK},
      '{instr(OP_LDA, 3'd3, 20'h00000, 6'b110000), 1'b1, ST_OK},
      '{instr(OP_LDA, 3'd3, 20'h00FFF, 6'b010000), 1'b1, ST_OK},
      '{instr(OP_LDA, 3'd0, 20'hFFFFF, 6'b111111), 1'b1, ST_OK},
      '{instr(OP_LDA, 3'd1, 20'h00000, 6'b110000), 1'b1, ST_OK},
      '{instr(OP_DIVR, 3'd2, 20'h00010, 6'b000000), 1'b1, ST_DIV0},
      '{instr(OP_ADDR, 3'd2, 20'h00060, 6'b000000), 1'b1, ST_BADREG},
      '{instr(OP_SHIFTL, 3'd2, 20'h0000F, 6'b000000), 1'b1, ST_OK},
      '{instr(OP_SHIFTR, 3'd2, 20'h0000F, 6'b000000), 1'b1, ST_OK},
      '{instr(OP_CLEAR, 3'd2, 20'h00060, 6'b000000), 1'b1, ST_BADREG},
      '{instr(OP_DIV, 3'd3, 20'h00000, 6'b010000), 1'b1, ST_DIV0},
      '{instr(OP_STA, 3'd4, 20'hFFFFF, 6'b110001), 1'b1, ST_ADDR},
      '{instr(OP_LDA, 3'd4, 20'hFFFFF, 6'b010001), 1'b1, ST_OK},
      '{instr(OP_COMP, 3'd3, 20'h00FFF, 6'b010000), 1'b0, ST_OK},
      '{instr(OP_TD, 3'd3, 20'h00000, 6'b110000), 1'b0, ST_OK},
      '{instr(OP_JSUB, 3'd3, 20'h00100, 6'b010000), 1'b0, ST_OK},
      '{instr(OP_RSUB, 3'd3, 20'h00000, 6'b110000), 1'b0, ST_OK},
      '{instr(OP_TIXR, 3'd2, 20'h00000, 6'b000000), 1'b0, ST_OK},
      '{instr(OP_STCH, 3'd4, 20'h0000A, 6'b110001), 1'b1, ST_OK},
      '{instr(OP_LDCH, 3'd4, 20'h0000A, 6'b110001), 1'b1, ST_OK},
      '{instr(OP_LDA, 3'd3, 20'h00000, 6'b000000), 1'b1, ST_OK},
      '{instr(OP_STA, 3'd3, 20'h00000, 6'b100000), 1'b1, ST_OK},
      '{instr(OP_LDA, 3'd3, 20'h00000, 6'b100000), 1'b1, ST_OK}
    };
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[k]) begin
      send_word(rows[k].w, rows[k].typed, rows[k].status);
    end
    // Any word that would read a byte never written is replaced by a write to it.
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      if (k > RANDOM_WORDS * 85 / 100) quiet = 1'b1;
      w = random_word();
      execute_word(w, 1'b0, probe, blank);
      if (blank >= 0) begin
        w = byte_write(blank, $urandom());
      end
      send_word(w, 1'b0, ST_OK);
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    waited = 0;
    while (waited < 60) begin
      @(posedge clk);
      waited++;
    end
    if (errors == 0) begin
      $display("sicxe_instruction_execute_core_test passed");
    end else begin
      $display("sicxe_instruction_execute_core_test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
